[design/adsr_envelope_generator_core_assert.svh]
// Assertion macros for the envelope generator.
`ifndef ADSR_ENVELOPE_GENERATOR_CORE_ASSERT_SVH
`define ADSR_ENVELOPE_GENERATOR_CORE_ASSERT_SVH
`ifndef SYNTH
`define ADSR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");
`define ADSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");
`else
`define ADSR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define ADSR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[design/adsr_env_pkg.sv]
`timescale 1ns / 1ps
package adsr_env_pkg;

   localparam logic [2:0] PH_OFF     = 3'd0;
   localparam logic [2:0] PH_ATTACK  = 3'd1;
   localparam logic [2:0] PH_DECAY   = 3'd2;
   localparam logic [2:0] PH_SUSTAIN = 3'd3;
   localparam logic [2:0] PH_RELEASE = 3'd4;

   localparam logic [2:0] OP_TICK    = 3'd0;
   localparam logic [2:0] OP_KEY_ON  = 3'd1;
   localparam logic [2:0] OP_KEY_OFF = 3'd2;
   localparam logic [2:0] OP_STOP    = 3'd3;
   localparam logic [2:0] OP_WRITE   = 3'd4;

   localparam logic signed [15:0] LEVEL_MAX = 16'sh7fff;
   localparam logic signed [15:0] EXPO_KNEE = 16'sh6000;

   typedef struct packed {
      logic              active;
      logic              expo;
      logic              decrease;
      logic [4:0]        shift;
      logic signed [4:0] stepv;
      logic [15:0]       sustain_thr;
   } env_param_type;

endpackage

[design/adsr_env_decode.sv]
`timescale 1ns / 1ps
module adsr_env_decode (
   input  logic [31:0]                  settings,
   input  logic [2:0]                   phase,
   output adsr_env_pkg::env_param_type  param
);
   import adsr_env_pkg::*;

   always_comb begin
      param = '0;
      param.sustain_thr = {5'({1'b0, settings[3:0]}) + 5'd1, 11'd0};
      unique case (phase)
         PH_ATTACK: begin
            param.active = 1'b1;
            param.expo   = settings[15];
            param.shift  = settings[14:10];
            param.stepv  = $signed(5'd7 - {3'd0, settings[9:8]});
         end
         PH_DECAY: begin
            param.active   = 1'b1;
            param.expo     = 1'b1;
            param.decrease = 1'b1;
            param.shift    = {1'b0, settings[7:4]};
            param.stepv    = -5'sd8;
         end
         PH_SUSTAIN: begin
            param.active   = 1'b1;
            param.expo     = settings[31];
            param.decrease = settings[30];
            param.shift    = settings[28:24];
            if (settings[30]) begin
               param.stepv = $signed(5'b11000 + {3'd0, settings[23:22]});
            end else begin
               param.stepv = $signed(5'd7 - {3'd0, settings[23:22]});
            end
         end
         PH_RELEASE: begin
            param.active   = 1'b1;
            param.expo     = settings[21];
            param.decrease = 1'b1;
            param.shift    = settings[20:16];
            param.stepv    = -5'sd8;
         end
         default: begin
            param.active = 1'b0;
         end
      endcase
   end

endmodule

[design/adsr_env_step.sv]
`timescale 1ns / 1ps
module adsr_env_step (
   input  logic [2:0]                   operation,
   input  logic signed [15:0]           written_level,
   input  adsr_env_pkg::env_param_type  param,
   input  logic [2:0]                   phase_ff,
   input  logic signed [15:0]           level_ff,
   input  logic [22:0]                  wait_ff,
   output logic [2:0]                   phase_in,
   output logic signed [15:0]           level_in,
   output logic [22:0]                  wait_in
);
   import adsr_env_pkg::*;

   logic [22:0]        wait_dec;
   logic [22:0]        cycles;
   logic signed [15:0] step_lin;
   logic signed [31:0] prod;
   logic signed [31:0] quot;
   logic signed [17:0] step_fin;
   logic signed [17:0] sum;
   logic signed [15:0] clamped;

   always_comb begin
      wait_dec = (wait_ff != 23'd0) ? (wait_ff - 23'd1) : wait_ff;

      if (param.shift > 5'd11) begin
         cycles = 23'd1 << (param.shift - 5'd11);
      end else begin
         cycles = 23'd1;
      end
      if (param.expo && !param.decrease && (level_ff > EXPO_KNEE)) begin
         cycles = cycles << 2;
      end

      if (param.shift < 5'd11) begin
         step_lin = {{11{param.stepv[4]}}, param.stepv} << (5'd11 - param.shift);
      end else begin
         step_lin = {{11{param.stepv[4]}}, param.stepv};
      end

      // Division by 0x8000 truncates toward zero, so negative products are biased.
      prod = step_lin * level_ff;
      if (prod[31]) begin
         quot = (prod + 32'sd32767) >>> 15;
      end else begin
         quot = prod >>> 15;
      end

      if (param.expo && param.decrease) begin
         step_fin = quot[17:0];
      end else begin
         step_fin = {{2{step_lin[15]}}, step_lin};
      end

      sum = {{2{level_ff[15]}}, level_ff} + step_fin;
      if (sum < 18'sd0) begin
         clamped = 16'sd0;
      end else if (sum > 18'sd32767) begin
         clamped = LEVEL_MAX;
      end else begin
         clamped = sum[15:0];
      end
   end

   always_comb begin
      phase_in = phase_ff;
      level_in = level_ff;
      wait_in  = wait_ff;
      unique case (operation)
         OP_TICK: begin
            if (param.active) begin
               wait_in = wait_dec;
               if (wait_dec == 23'd0) begin
                  wait_in  = cycles;
                  level_in = clamped;
                  if ((phase_ff == PH_ATTACK) && (clamped == LEVEL_MAX)) begin
                     phase_in = PH_DECAY;
                     wait_in  = 23'd0;
                  end else if ((phase_ff == PH_DECAY) &&
                               ($unsigned(clamped) <= param.sustain_thr)) begin
                     phase_in = PH_SUSTAIN;
                     wait_in  = 23'd0;
                  end else if ((phase_ff == PH_RELEASE) && (clamped == 16'sd0)) begin
                     phase_in = PH_OFF;
                     wait_in  = 23'd0;
                  end
               end
            end
         end
         OP_KEY_ON: begin
            phase_in = PH_ATTACK;
            level_in = 16'sd0;
            wait_in  = 23'd0;
         end
         OP_KEY_OFF: begin
            phase_in = PH_RELEASE;
            wait_in  = 23'd0;
         end
         OP_STOP: begin
            phase_in = PH_RELEASE;
            level_in = 16'sd0;
            wait_in  = 23'd0;
         end
         OP_WRITE: begin
            level_in = written_level;
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

endmodule

[design/adsr_envelope_generator_core.sv]
`timescale 1ns / 1ps
// Channel   Direction  Contents
// req       in         tuser: operation; tdata: written_level
// rsp       out        tdata: level, phase
// csr       in         envelope settings write, no read-back
// An item is registered on acceptance, its result when the output stage is free.
// One item is accepted every cycle while the result side keeps up.
// The envelope update is one pass through one 16 by 16 multiplier and two adds.
// Reset clears the phase, level, wait counter, settings and both valid flags.
// A stalled result holds the input stage, which still takes one item if empty.
`include "adsr_envelope_generator_core_assert.svh"
module adsr_envelope_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] written_level
   input  logic [2:0]  req_tuser,   // [2:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [15:0] level, [18:16] phase, [23:19] zero
   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);
   import adsr_env_pkg::*;

   logic               in_valid_ff;
   logic [2:0]         in_op_ff;
   logic signed [15:0] in_wl_ff;
   logic               out_valid_ff;
   logic signed [15:0] out_level_ff;
   logic [2:0]         out_phase_ff;
   logic [31:0]        settings_ff;
   logic [2:0]         phase_ff;
   logic signed [15:0] level_ff;
   logic [22:0]        wait_ff;
   logic [2:0]         phase_in;
   logic signed [15:0] level_in;
   logic [22:0]        wait_in;
   logic               advance;
   env_param_type      param;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'd0, out_phase_ff, out_level_ff};

   adsr_env_decode u_decode (
      .settings (settings_ff),
      .phase    (phase_ff),
      .param    (param)
   );

   adsr_env_step u_step (
      .operation     (in_op_ff),
      .written_level (in_wl_ff),
      .param         (param),
      .phase_ff      (phase_ff),
      .level_ff      (level_ff),
      .wait_ff       (wait_ff),
      .phase_in      (phase_in),
      .level_in      (level_in),
      .wait_in       (wait_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         settings_ff  <= 32'd0;
         phase_ff     <= PH_OFF;
         level_ff     <= 16'sd0;
         wait_ff      <= 23'd0;
      end else begin
         if (csr_we) begin
            settings_ff <= csr_wdata;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
            if (in_valid_ff) begin
               phase_ff <= phase_in;
               level_ff <= level_in;
               wait_ff  <= wait_in;
            end
         end
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_op_ff <= req_tuser;
         in_wl_ff <= $signed(req_tdata);
      end
      if (advance && in_valid_ff) begin
         out_level_ff <= level_in;
         out_phase_ff <= phase_in;
      end
   end

   `ADSR_ASSERT_SAME(a_off_wait_clear, clock, reset, phase_ff == PH_OFF, wait_ff == 23'd0)
   `ADSR_ASSERT_NEXT(a_held_item, clock, reset, in_valid_ff && !advance, in_valid_ff)
   `ADSR_ASSERT_SAME(a_attack_done_full, clock, reset, (phase_ff == PH_DECAY) && ($past(phase_ff) == PH_ATTACK), level_ff == LEVEL_MAX)
   `ADSR_ASSERT_SAME(a_release_done_zero, clock, reset, (phase_ff == PH_OFF) && ($past(phase_ff) == PH_RELEASE), level_ff == 16'sd0)

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
module testbench;
   import adsr_env_pkg::*;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   localparam int LEVEL_FULL_SCALE = 32768;
   localparam int SUSTAIN_UNIT     = 2048;
   localparam int SESSION_ITEMS    = 100;

   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] level;
   } envelope_sample_type;

   class envelope_scoreboard;
      logic [31:0]         settings;
      logic [2:0]          phase;
      logic [15:0]         level;
      logic [22:0]         wait_count;
      envelope_sample_type expected_samples[$];
      int unsigned         failures;
      int unsigned         samples_checked;

      function new();
         settings = '0;
         phase = PH_OFF;
         level = '0;
         wait_count = '0;
         failures = 0;
         samples_checked = 0;
      endfunction

      function void load_settings(input logic [31:0] value);
         settings = value;
      endfunction

      function void note_item(input logic [2:0] op, input logic [15:0] written);
         envelope_sample_type sample;
         logic active, expo, decrease;
         int shift, stepv, lvl, thr, cycles, step, nl;
         case (op)
            OP_TICK: begin
               active = 1'b1;
               expo = 1'b0;
               decrease = 1'b0;
               shift = 0;
               stepv = 0;
               lvl = int'(signed'(level));
               thr = (int'(settings[3:0]) + 1) * SUSTAIN_UNIT;
               case (phase)
                  PH_ATTACK: begin
                     expo = settings[15];
                     shift = int'(settings[14:10]);
                     stepv = 7 - int'(settings[9:8]);
                  end
                  PH_DECAY: begin
                     expo = 1'b1;
                     decrease = 1'b1;
                     shift = int'(settings[7:4]);
                     stepv = -8;
                  end
                  PH_SUSTAIN: begin
                     expo = settings[31];
                     decrease = settings[30];
                     shift = int'(settings[28:24]);
                     stepv = decrease ? int'(settings[23:22]) - 8 : 7 - int'(settings[23:22]);
                  end
                  PH_RELEASE: begin
                     expo = settings[21];
                     decrease = 1'b1;
                     shift = int'(settings[20:16]);
                     stepv = -8;
                  end
                  default: active = 1'b0;
               endcase
               if (active) begin
                  if (wait_count != '0) wait_count = wait_count - 23'd1;
                  cycles = (shift > 11) ? (1 << (shift - 11)) : 1;
                  step = stepv * ((shift < 11) ? (1 << (11 - shift)) : 1);
                  // Expo rise slows past the knee; expo fall scales by level.
                  if (expo && !decrease && lvl > EXPO_KNEE) cycles = cycles * 4;
                  else if (expo && decrease) step = (step * lvl) / LEVEL_FULL_SCALE;
                  if (wait_count == '0) begin
                     wait_count = cycles[22:0];
                     nl = lvl + step;
                     if (nl < 0) nl = 0;
                     if (nl > LEVEL_MAX) nl = LEVEL_MAX;
                     level = nl[15:0];
                     if (phase == PH_ATTACK && nl == LEVEL_MAX) begin
                        phase = PH_DECAY;
                        wait_count = '0;
                     end else if (phase == PH_DECAY && nl <= thr) begin
                        phase = PH_SUSTAIN;
                        wait_count = '0;
                     end else if (phase == PH_RELEASE && nl == 0) begin
                        phase = PH_OFF;
                        wait_count = '0;
                     end
                  end
               end
            end
            OP_KEY_ON: begin
               phase = PH_ATTACK;
               level = '0;
               wait_count = '0;
            end
            OP_KEY_OFF: begin
               phase = PH_RELEASE;
               wait_count = '0;
            end
            OP_STOP: begin
               phase = PH_RELEASE;
               wait_count = '0;
               level = '0;
            end
            OP_WRITE: level = written;
            default: ;
         endcase
         sample.phase = phase;
         sample.level = level;
         expected_samples.push_back(sample);
      endfunction

      function void check_result(input logic [23:0] data);
         envelope_sample_type want;
         samples_checked++;
         if (expected_samples.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected result: level %h phase %0d", data[15:0], data[18:16]);
            return;
         end
         want = expected_samples.pop_front();
         if (data[15:0] !== want.level || data[18:16] !== want.phase) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: expected level %h phase %0d, got level %h phase %0d",
                        want.level, want.phase, data[15:0], data[18:16]);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;

   envelope_scoreboard board = new();
   int unsigned items_sent = 0;
   int unsigned items_counted = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;

   adsr_envelope_generator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("adsr_envelope_generator_core regression: fail");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_we) board.load_settings(csr_wdata);
         if (rsp_tvalid && rsp_tready) board.check_result(rsp_tdata);
         if (req_tvalid && req_tready) board.note_item(req_tuser, req_tdata);
      end
   end

   // A long hold-off lets the block fill up and push back on its input.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [15:0] written);
      if ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < gap_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= written;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (op <= OP_WRITE) items_counted++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.samples_checked != items_sent) @(posedge clock);
   endtask

   task automatic write_settings(input logic [31:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [4:0] pick_shift();
      return ($urandom_range(3) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(0, 3));
   endfunction

   function automatic logic [31:0] random_settings();
      logic [31:0] value;
      logic [4:0]  shift;
      value = $urandom;
      if ($urandom_range(3) != 0) begin
         value[14:10] = pick_shift();
         shift = pick_shift();
         value[7:4] = shift[3:0];
         value[20:16] = pick_shift();
         value[28:24] = pick_shift();
      end
      return value;
   endfunction

   task automatic play_note();
      int unsigned attack_ticks;
      int unsigned release_ticks;
      send_item(OP_KEY_ON, 16'($urandom));
      attack_ticks = $urandom_range(1, 60);
      repeat (attack_ticks) begin
         case ($urandom_range(39))
            0: send_item(OP_WRITE, 16'($urandom));
            1: send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), 16'($urandom));
            default: send_item(OP_TICK, 16'($urandom));
         endcase
      end
      send_item(($urandom_range(1) == 0) ? OP_KEY_OFF : OP_STOP, 16'($urandom));
      release_ticks = $urandom_range(1, 40);
      repeat (release_ticks) send_item(OP_TICK, 16'($urandom));
   endtask

   task automatic play_noise();
      repeat ($urandom_range(1, 8))
         send_item(3'($urandom_range(OP_TICK, OP_SPARE_LAST)), 16'($urandom));
   endtask

   initial begin
      int session;
      int unsigned target;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Fast linear attack, halving decay, sustain level seven.
      write_settings(32'h0000_0007);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_SPARE_FIRST, 16'hffff);
      send_item(OP_SPARE_FIRST + 3'd1, 16'h0000);
      send_item(OP_SPARE_LAST, 16'hffff);
      send_item(OP_WRITE, 16'h8000);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_WRITE, 16'h7fff);
      send_item(OP_KEY_ON, 16'h0000);
      repeat (5) send_item(OP_TICK, 16'h0000);
      send_item(OP_KEY_OFF, 16'h0000);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_WRITE, 16'hfffb);
      send_item(OP_TICK, 16'h0000);
      send_item(OP_STOP, 16'h0000);
      send_item(OP_TICK, 16'h0000);

      // The top sustain level ends decay on its first step.
      write_settings(32'h0000_000f);
      send_item(OP_KEY_ON, 16'h0000);
      repeat (4) send_item(OP_TICK, 16'h0000);
      send_item(OP_KEY_OFF, 16'h0000);

      for (session = 0; session < 8; session++) begin
         case (session % 4)
            0: begin
               gap_pct = 0;
               stall_pct = 0;
            end
            1: begin
               gap_pct = 57;
               stall_pct = 0;
            end
            2: begin
               gap_pct = 0;
               stall_pct = 57;
            end
            default: begin
               gap_pct = 13;
               stall_pct = 13;
            end
         endcase
         if (session == 0) write_settings(32'h0000_0000);
         else if (session == 1) write_settings(32'hffff_ffff);
         else write_settings(random_settings());
         if (session == 4) begin
            hold_cycles = 300;
            play_note();
         end
         target = items_counted + SESSION_ITEMS;
         while (items_counted < target) begin
            if ($urandom_range(3) != 0) play_note();
            else play_noise();
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (board.expected_samples.size() != 0)
         $display("%0d expected results never arrived", board.expected_samples.size());
      if (board.failures == 0 && board.expected_samples.size() == 0)
         $display("adsr_envelope_generator_core regression: pass");
      else
         $display("adsr_envelope_generator_core regression: fail");
      $finish;
   end

endmodule
